// File: design/ffrr_pkg.sv
// ----------------------------------------------------------------------------
// Frame resync receiver package
// Shared constants, status codes and float range helpers.
// ----------------------------------------------------------------------------
package ffrr_pkg;

   localparam int FrameBytes = 36;
   localparam int NumValues  = 8;
   localparam int FillWidth  = 6;

   localparam logic [31:0] EndMarkerReset = 32'h7F80_0000;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MARKER   = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] stick_0;
      logic [31:0] stick_1;
      logic [31:0] stick_2;
      logic [31:0] stick_3;
      logic [31:0] color_value;
      logic [31:0] first_count;
      logic [31:0] second_count;
      logic [31:0] third_count;
   } rsp_type;

   // Float limits as IEEE single magnitudes.
   localparam logic [30:0] Mag600 = 31'h4416_0000;
   localparam logic [30:0] Mag2   = 31'h4000_0000;
   localparam logic [30:0] Mag12  = 31'h4140_0000;

   function automatic logic is_nan(input logic [31:0] v);
      is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   // Passes when |v| <= lim, or NaN.
   function automatic logic sym_ok(input logic [31:0] v, input logic [30:0] lim);
      sym_ok = is_nan(v) || (v[30:0] <= lim);
   endfunction

   // Passes when 0 <= v <= lim (negative zero counts as zero), or NaN.
   function automatic logic pos_ok(input logic [31:0] v, input logic [30:0] lim);
      pos_ok = is_nan(v) || (v[30:0] == 31'd0) || (!v[31] && (v[30:0] <= lim));
   endfunction

endpackage

// File: design/ffrr_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one word of a generic payload width.
// ----------------------------------------------------------------------------
interface ffrr_stream_if #(parameter int Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: design/ffrr_check.sv
// ----------------------------------------------------------------------------
// Frame check
// Combinational marker and range check over a full window.
// ----------------------------------------------------------------------------
module ffrr_check (
   input  logic [8*ffrr_pkg::FrameBytes-1:0] frame,
   input  logic [31:0]                       end_marker,
   output ffrr_pkg::rsp_type                 rsp
);
   logic [31:0] w [ffrr_pkg::NumValues];
   logic        marker_ok;
   logic        range_ok;

   always_comb begin
      for (int i = 0; i < ffrr_pkg::NumValues; i++) begin
         w[i] = frame[32*i +: 32];
      end
      marker_ok = (frame[8*ffrr_pkg::FrameBytes-1 -: 32] == end_marker);
      range_ok = ffrr_pkg::sym_ok(w[0], ffrr_pkg::Mag600)
         && ffrr_pkg::sym_ok(w[1], ffrr_pkg::Mag600)
         && ffrr_pkg::sym_ok(w[2], ffrr_pkg::Mag600)
         && ffrr_pkg::sym_ok(w[3], ffrr_pkg::Mag600)
         && ffrr_pkg::pos_ok(w[4], ffrr_pkg::Mag2)
         && ffrr_pkg::pos_ok(w[5], ffrr_pkg::Mag12)
         && ffrr_pkg::pos_ok(w[6], ffrr_pkg::Mag12)
         && ffrr_pkg::pos_ok(w[7], ffrr_pkg::Mag12);
      rsp = '0;
      if (!marker_ok) begin
         rsp.status = ffrr_pkg::STATUS_MARKER;
      end else if (!range_ok) begin
         rsp.status = ffrr_pkg::STATUS_RANGE;
      end else begin
         rsp.status       = ffrr_pkg::STATUS_OK;
         rsp.stick_0      = w[0];
         rsp.stick_1      = w[1];
         rsp.stick_2      = w[2];
         rsp.stick_3      = w[3];
         rsp.color_value  = w[4];
         rsp.first_count  = w[5];
         rsp.second_count = w[6];
         rsp.third_count  = w[7];
      end
   end
endmodule

// File: design/float_frame_resync_receiver_unit.sv
// ----------------------------------------------------------------------------
// Float frame resync receiver
// Collects bytes into a 36-byte window and checks each full frame.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// req       in         rx_byte (8)
// rsp       out        status (2), eight 32-bit float words
// csr       in         end_marker write (32)
// One byte is taken per cycle while the input is not stalled; a byte that fills the
// window yields a word in the next cycle from the result register, set by the single pass frame check.
// The input stalls only while a result is held and the downstream is stalled.
// Reset empties the window and restores the default end marker.
// ----------------------------------------------------------------------------
module float_frame_resync_receiver_unit (
   input  logic                     clock,
   input  logic                     reset,
   ffrr_stream_if.sink              req,
   ffrr_stream_if.source            rsp,
   input  logic                     csr_we,
   input  logic [31:0]              csr_wdata
);
   logic [7:0]                         win_ff [ffrr_pkg::FrameBytes];
   logic [ffrr_pkg::FillWidth-1:0]     fill_ff;
   logic [ffrr_pkg::FillWidth-1:0]     fill_in;
   logic [31:0]                        marker_ff;
   logic                               out_valid_ff;
   ffrr_pkg::rsp_type                  out_ff;
   ffrr_pkg::rsp_type                  chk_rsp;
   logic [8*ffrr_pkg::FrameBytes-1:0]  frame;
   logic                               take;
   logic                               full;
   localparam logic [ffrr_pkg::FillWidth-1:0] LastPos =
      ffrr_pkg::FillWidth'(ffrr_pkg::FrameBytes - 1);

   assign req.ready = !out_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;
   assign full      = (fill_ff == LastPos);

   always_comb begin
      for (int i = 0; i < ffrr_pkg::FrameBytes - 1; i++) begin
         frame[8*i +: 8] = win_ff[i];
      end
      frame[8*ffrr_pkg::FrameBytes-1 -: 8] = req.data;
   end

   ffrr_check u_check (
      .frame      (frame),
      .end_marker (marker_ff),
      .rsp        (chk_rsp)
   );

   always_comb begin
      fill_in = fill_ff;
      if (take) begin
         if (!full) begin
            fill_in = fill_ff + 1'b1;
         end else if (chk_rsp.status == ffrr_pkg::STATUS_OK) begin
            fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         marker_ff    <= ffrr_pkg::EndMarkerReset;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (csr_we) begin
            marker_ff <= csr_wdata;
         end
         if (take && full) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (full) begin
            out_ff <= chk_rsp;
            for (int i = 0; i < ffrr_pkg::FrameBytes - 2; i++) begin
               win_ff[i] <= win_ff[i+1];
            end
            win_ff[ffrr_pkg::FrameBytes-2] <= req.data;
         end else begin
            win_ff[fill_ff] <= req.data;
         end
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LastPos) else $error("fill level beyond window");
   a_result_on_full: assert property (@(posedge clock) disable iff (reset)
      take && full |=> rsp.valid) else $error("full window gave no result");
   a_reject_slides: assert property (@(posedge clock) disable iff (reset)
      take && full && chk_rsp.status != ffrr_pkg::STATUS_OK |=> fill_ff == LastPos)
      else $error("rejected frame did not slide");
endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Float frame resync receiver testbench
// Feeds bytes as whole frames, broken frames and noise, changes the end
// marker between idle phases, and checks every result word as a whole against
// an in-bench model of the window, the marker and the range tests (or a typed row's result).
// ----------------------------------------------------------------------------
module testbench;
   import ffrr_pkg::*;

   typedef struct {
      logic [7:0][31:0] vals;
      logic [31:0]      mark;
      bit               typed;
      status_type       st;
   } frame_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   ffrr_stream_if #(.Width(8)) req_if ();
   ffrr_stream_if #(.Width($bits(rsp_type))) rsp_if ();

   float_frame_resync_receiver_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
   end

   logic [7:0]  win_bytes [FrameBytes];
   int          win_fill;
   logic [31:0] cur_marker;
   rsp_type     frame_queue [$];
   bit          calm = 1'b0;
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          frames_ok = 0;
   int          frames_bad = 0;

   function automatic bit nan_bits(logic [31:0] v);
      return v[30:23] == 8'hFF && v[22:0] != 0;
   endfunction

   function automatic bit stick_fits(logic [31:0] v);
      return nan_bits(v) || v[30:0] <= 31'h4416_0000;
   endfunction

   function automatic bit unsigned_fits(logic [31:0] v, logic [30:0] lim);
      return nan_bits(v) || v[30:0] == 0 || (!v[31] && v[30:0] <= lim);
   endfunction

   // Stores one byte and returns a result when the window fills.
   function automatic bit window_push(logic [7:0] b, output rsp_type res);
      logic [31:0] w [9];
      bit good;
      res = '0;
      if (win_fill >= FrameBytes) win_fill = 0;
      win_bytes[win_fill] = b;
      win_fill++;
      if (win_fill < FrameBytes) return 0;
      for (int i = 0; i < 9; i++)
         w[i] = {win_bytes[4*i+3], win_bytes[4*i+2], win_bytes[4*i+1], win_bytes[4*i]};
      good = 1;
      for (int i = 0; i < 4; i++) good &= stick_fits(w[i]);
      good &= unsigned_fits(w[4], 31'h4000_0000);
      for (int i = 5; i < 8; i++) good &= unsigned_fits(w[i], 31'h4140_0000);
      if (w[8] != cur_marker) res.status = STATUS_MARKER;
      else if (!good) res.status = STATUS_RANGE;
      else res.status = STATUS_OK;
      if (res.status == STATUS_OK) begin
         {res.stick_0, res.stick_1, res.stick_2, res.stick_3} = {w[0], w[1], w[2], w[3]};
         {res.color_value, res.first_count} = {w[4], w[5]};
         {res.second_count, res.third_count} = {w[6], w[7]};
         win_fill = 0;
         frames_ok++;
      end else begin
         for (int i = 0; i < FrameBytes - 1; i++) win_bytes[i] = win_bytes[i+1];
         win_fill = FrameBytes - 1;
         frames_bad++;
      end
      return 1;
   endfunction

   task automatic send_byte(logic [7:0] b, bit typed = 0, rsp_type typed_res = '0);
      rsp_type res;
      while (!calm && $urandom_range(99) < 35) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= b;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
      if (window_push(b, res)) frame_queue.push_back(typed ? typed_res : res);
   endtask

   task automatic send_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (frame_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_marker(logic [31:0] m);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_marker = m;
   endtask

   function automatic logic [31:0] pick_value(int slot, bit in_range);
      logic [30:0] lim;
      bit sgn;
      lim = slot < 4 ? 31'h4416_0000 : slot == 4 ? 31'h4000_0000 : 31'h4140_0000;
      if ($urandom_range(19) == 0)
         return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      if (in_range) begin
         sgn = slot < 4 ? 1'($urandom_range(1)) : 1'b0;
         case ($urandom_range(3))
            0: return {sgn, lim};
            1: return {1'($urandom_range(1)), 31'd0};
            default: return {sgn, 31'($urandom_range(0, lim))};
         endcase
      end
      if (slot >= 4 && $urandom_range(1)) return {1'b1, 31'($urandom_range(1, 32'h7F80_0000))};
      return {1'($urandom_range(1)), 31'($urandom_range(lim + 1, 32'h7F80_0000))};
   endfunction

   task automatic send_frame(bit broken);
      int bad_slot;
      bad_slot = broken ? $urandom_range(7) : -1;
      for (int i = 0; i < 8; i++) send_word(pick_value(i, i != bad_slot));
      send_word($urandom_range(9) == 0 ? $urandom : cur_marker);
   endtask

   task automatic random_phase(int count);
      int stop;
      stop = bytes_sent + count;
      while (bytes_sent < stop) begin
         case ($urandom_range(19))
            0, 1: repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
            2, 3: repeat ($urandom_range(1, 35)) send_byte(8'($urandom));
            4, 5: send_frame(1);
            default: send_frame(0);
         endcase
      end
   endtask

   frame_row_type rows [8];

   initial begin
      rows[0] = '{'0, EndMarkerReset, 1, STATUS_OK};
      rows[1] = '{{32'h4416_0000, 32'hC416_0000, 32'h8000_0000, 32'h0000_0001,
                   32'h4000_0000, 32'h4140_0000, 32'h0000_0000, 32'h8000_0000},
                  EndMarkerReset, 1, STATUS_OK};
      rows[2] = '{{32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h3F80_0000,
                   32'hFFC0_0000, 32'h7FFF_FFFF, 32'hFF80_0001, 32'h4120_0000},
                  EndMarkerReset, 1, STATUS_OK};
      rows[3] = '{{32'h4416_0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
                  EndMarkerReset, 1, STATUS_RANGE};
      rows[4] = '{{32'h7F80_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
                  32'h1234_5678, 0, STATUS_OK};
      rows[5] = '{{32'h0, 32'h0, 32'h0, 32'h0, 32'hBF80_0000, 32'h0, 32'h0, 32'h0},
                  EndMarkerReset, 0, STATUS_OK};
      rows[6] = '{{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h4140_0001},
                  EndMarkerReset, 0, STATUS_OK};
      rows[7] = '{{32'hFF80_0000, 32'h0, 32'h0, 32'h0, 32'h4000_0001, 32'h0, 32'h0,
                   32'hC140_0000}, EndMarkerReset, 0, STATUS_OK};
   end

   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= calm || $urandom_range(99) >= 35;
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (frame_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %h", got);
         end else begin
            want = frame_queue.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   initial begin
      rsp_type typed_res;
      win_fill = 0;
      cur_marker = EndMarkerReset;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[r]) begin
         for (int i = 0; i < 8; i++) send_word(rows[r].vals[7-i]);
         for (int i = 0; i < 3; i++) send_byte(rows[r].mark[8*i +: 8]);
         typed_res = '0;
         typed_res.status = rows[r].st;
         if (rows[r].st == STATUS_OK)
            {typed_res.stick_0, typed_res.stick_1, typed_res.stick_2, typed_res.stick_3,
             typed_res.color_value, typed_res.first_count, typed_res.second_count,
             typed_res.third_count} = rows[r].vals;
         send_byte(rows[r].mark[31:24], rows[r].typed, typed_res);
      end

      random_phase(380);
      write_marker(32'h0000_0000);
      random_phase(200);
      calm = 1'b1;
      write_marker(32'hFFFF_FFFF);
      random_phase(200);
      calm = 1'b0;
      write_marker($urandom);
      random_phase(200);
      write_marker(EndMarkerReset);
      random_phase(340);

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes over five end marker settings.", bytes_sent);
      $display("Frames accepted: %0d, frames rejected: %0d.", frames_ok, frames_bad);
      if (mismatches == 0 && frame_queue.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: files.f
design/ffrr_pkg.sv
design/ffrr_stream_if.sv
design/ffrr_check.sv
design/float_frame_resync_receiver_unit.sv
bench/testbench.sv
